// ===== rtl/hsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_pkg: shared types and constants of the haptic strength decay block
// Holds the request codes, register indexes, channel state entry, stage
// records and the fixed-point constants of the decay arithmetic.
// ----------------------------------------------------------------------------
package hsd_pkg;

  // Request codes carried in req_type.
  typedef enum logic [0:0] {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_DECAY_SPEED = 1'b0,
    CFG_HOLD_DELAY  = 1'b1
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [7:0]  DECAY_SPEED_RST = 8'd20;
  localparam logic [31:0] HOLD_DELAY_RST  = 32'd10000;

  // Elapsed time is clipped to 18 bits: beyond 2^18 ms any nonzero speed
  // already removes more than 255 units.
  localparam int unsigned SINCE_W = 18;
  localparam int unsigned PROD_W  = SINCE_W + 8;

  // Division by 1000 as a multiplication by ceil(2^36 / 1000) and a shift;
  // exact for every product below 2^26.
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned SCALED_W    = PROD_W + RECIP_W;
  localparam int unsigned QUOT_W      = SCALED_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;

  // Result queue.
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = 3;
  localparam int unsigned OUT_CNT_W = OUT_PTR_W + 1;
  localparam logic [OUT_CNT_W-1:0] OUT_CREDITS = OUT_CNT_W'(OUT_DEPTH);

  // Per-channel state entry.
  typedef struct packed {
    logic [7:0]  last_input;
    logic [31:0] update_time;
    logic [7:0]  level;
  } entry_t;

  // Record of one request between the decision stage and write-back.
  // level holds the final level unless take is set; then it is the level
  // before decay.
  typedef struct packed {
    logic [3:0]         channel;
    logic               in_range;
    logic               take;
    logic [7:0]         last_input;
    logic [31:0]        update_time;
    logic [7:0]         level;
    logic [SINCE_W-1:0] since;
    logic               since_sat;
  } stage_t;

  // One queued result.
  typedef struct packed {
    logic [3:0] channel;
    logic [7:0] level;
  } result_t;

endpackage

// ===== rtl/hsd_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_req_if: request channel of the haptic strength decay block
// Valid/ready handshake with one strength sample or refresh tick.
// ----------------------------------------------------------------------------
interface hsd_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  channel;
  logic [7:0]  strength;
  logic [31:0] now_ms;

  modport source (output valid, req_type, channel, strength, now_ms, input ready);
  modport sink   (input valid, req_type, channel, strength, now_ms, output ready);
endinterface

// ===== rtl/hsd_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_rsp_if: result channel of the haptic strength decay block
// Valid/ready handshake with one channel drive update.
// ----------------------------------------------------------------------------
interface hsd_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_channel;
  logic [7:0]  level;
  logic [11:0] duty;

  modport source (output valid, out_channel, level, duty, input ready);
  modport sink   (input valid, out_channel, level, duty, output ready);
endinterface

// ===== rtl/hsd_decay_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_decay_pipe: decay amount arithmetic
// Two stages after the decision: speed times elapsed time, then division by
// 1000 through a reciprocal, saturation and the floored subtraction.
// ----------------------------------------------------------------------------
module hsd_decay_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s1_vld_i,
  input  hsd_pkg::stage_t       s1_i,
  input  logic [7:0]            decay_speed_i,
  output logic                  s2_vld_o,
  output hsd_pkg::stage_t       s2_o,
  output logic                  s3_vld_o,
  output hsd_pkg::stage_t       s3_o,
  output logic [7:0]            s3_level_o
);

  logic                          s2_vld_q;
  hsd_pkg::stage_t               s2_q;
  logic                          s3_vld_q;
  hsd_pkg::stage_t               s3_q;
  logic [hsd_pkg::PROD_W-1:0]    prod_d, prod_q;
  logic                          sat_d, sat_q;
  logic [hsd_pkg::SCALED_W-1:0]  scaled;
  logic [hsd_pkg::QUOT_W-1:0]    quot;
  logic [7:0]                    amount;
  logic [7:0]                    decayed;

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_i;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Speed times elapsed milliseconds; a clipped elapsed time saturates
  // unless the speed is zero.
  always_comb begin
    prod_d = hsd_pkg::PROD_W'(s2_q.since) * hsd_pkg::PROD_W'(decay_speed_i);
    sat_d  = s2_q.since_sat && (decay_speed_i != 8'd0);
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    s2_q   <= s1_i;
    s3_q   <= s2_q;
    prod_q <= prod_d;
    sat_q  <= sat_d;
  end

  // Divide by 1000, saturate at 255 and subtract, floored at zero.
  always_comb begin
    scaled  = hsd_pkg::SCALED_W'(prod_q) * hsd_pkg::SCALED_W'(hsd_pkg::RECIP_1000);
    quot    = scaled[hsd_pkg::SCALED_W-1:hsd_pkg::RECIP_SHIFT];
    amount  = (sat_q || (quot > hsd_pkg::QUOT_W'(255))) ? 8'hFF : quot[7:0];
    decayed = (amount >= s3_q.level) ? 8'd0 : (s3_q.level - amount);
    if (!s3_q.in_range) begin
      s3_level_o = 8'd0;
    end else if (s3_q.take) begin
      s3_level_o = decayed;
    end else begin
      s3_level_o = s3_q.level;
    end
  end

  assign s2_vld_o = s2_vld_q;
  assign s2_o     = s2_q;
  assign s3_vld_o = s3_vld_q;
  assign s3_o     = s3_q;

endmodule

// ===== rtl/hsd_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_out_fifo: result queue
// Holds finished results until the receiver takes them; the top level
// admits requests only while a slot is reserved for each one.
// ----------------------------------------------------------------------------
module hsd_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hsd_pkg::result_t  push_data_i,
  input  logic              pop_i,
  output logic              vld_o,
  output hsd_pkg::result_t  data_o
);

  hsd_pkg::result_t              fifo_mem [hsd_pkg::OUT_DEPTH];
  logic [hsd_pkg::OUT_CNT_W-1:0] wr_ptr_q, rd_ptr_q;

  // Pointers carry one extra bit to tell full from empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_mem[wr_ptr_q[hsd_pkg::OUT_PTR_W-1:0]] <= push_data_i;
    end
  end

  assign vld_o  = (wr_ptr_q != rd_ptr_q);
  assign data_o = fifo_mem[rd_ptr_q[hsd_pkg::OUT_PTR_W-1:0]];

endmodule

// ===== rtl/haptic_strength_decay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_strength_decay: per-channel vibration strength with timed decay
// Keeps the last strength, its change time and the drive level of every
// channel in one state memory and decays levels after a hold delay.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one strength sample or refresh tick per request; rsp_o
//   returns one result per request, in order: channel, level and PWM duty.
//   Configuration writes (decay speed, hold delay) go through cfg_we_i,
//   cfg_idx_i and cfg_data_i while no request is in flight.
// Pipeline and throughput:
//   An accepted request passes the decision stage, the two arithmetic
//   stages and the result queue before its result shows on rsp_o. One
//   request is accepted every cycle while the queue has a free slot; a
//   request whose channel matches one of the two requests just ahead of it
//   that decayed the level waits until they finish, since the decision stage
//   needs that level from the arithmetic stages. The state memory is read
//   in the cycle before the decision; write-back is forwarded to that stage.
// Reset:
//   Every channel reads as zero until first written (one valid flag per
//   entry, so no clearing pass); the registers take their default values.
// Stalls:
//   Results wait in an eight-entry queue. Requests are taken only while
//   the queue has a slot for every request in flight, so a stalled receiver
//   holds off the sender without losing anything.
// ----------------------------------------------------------------------------
module haptic_strength_decay #(
  parameter int unsigned CHANNELS          = 16,
  parameter int unsigned REFRESH_PERIOD_MS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hsd_req_if.sink                        req_i,
  hsd_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [hsd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MEM_DEPTH = 1 << IDX_W;

  // Configuration registers.
  logic [7:0]  decay_speed_q;
  logic [31:0] hold_delay_q;

  // Decision stage.
  logic        s1_vld_q, s1_vld_d;
  logic        s1_type_q;
  logic [3:0]  s1_ch_q;
  logic [7:0]  s1_str_q;
  logic [31:0] s1_now_q;

  // State memory and its read and write ports.
  hsd_pkg::entry_t      state_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] ent_vld_q;
  hsd_pkg::entry_t      rd_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     raddr;
  logic                 mem_we;
  logic [IDX_W-1:0]     waddr;
  hsd_pkg::entry_t      wdata;

  // Copy of the write of the previous cycle.
  logic                 w_vld_q;
  logic [3:0]           w_ch_q;
  hsd_pkg::entry_t      w_ent_q;

  logic [31:0]          ldt_q;

  // Decision logic.
  hsd_pkg::entry_t      cur;
  logic                 in_range;
  logic [7:0]           req_str;
  logic                 changed;
  logic [31:0]          since;
  logic                 period_ok;
  logic                 hold_ok;
  hsd_pkg::stage_t      s1_stage;
  logic                 stall;
  logic                 s1_adv;

  // Arithmetic stages.
  logic                 s2_vld;
  hsd_pkg::stage_t      s2;
  logic                 s3_vld;
  hsd_pkg::stage_t      s3;
  logic [7:0]           s3_level;

  // Handshakes and queue.
  logic                          accept;
  logic                          deliver;
  logic [hsd_pkg::OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                          fifo_vld;
  hsd_pkg::result_t              fifo_data;
  hsd_pkg::result_t              push_data;

  // Configuration write decoder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_speed_q <= hsd_pkg::DECAY_SPEED_RST;
      hold_delay_q  <= hsd_pkg::HOLD_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (hsd_pkg::cfg_idx_e'(cfg_idx_i))
        hsd_pkg::CFG_DECAY_SPEED: decay_speed_q <= cfg_data_i[7:0];
        hsd_pkg::CFG_HOLD_DELAY:  hold_delay_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Request admission: one queue slot per request in flight.
  assign req_i.ready = !stall && (cnt_q < hsd_pkg::OUT_CREDITS);
  assign accept      = req_i.valid && req_i.ready;
  assign deliver     = rsp_o.valid && rsp_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !deliver) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!accept && deliver) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Decision stage holds its request while stalled.
  assign s1_vld_d = stall ? 1'b1 : accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      cnt_q    <= '0;
      ldt_q    <= '0;
      ent_vld_q <= '0;
      rd_vld_q <= 1'b0;
      w_vld_q  <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      cnt_q    <= cnt_d;
      if (s1_adv && s1_stage.take) begin
        ldt_q <= s1_now_q;
      end
      if (mem_we) begin
        ent_vld_q[waddr] <= 1'b1;
      end
      rd_vld_q <= ent_vld_q[raddr];
      w_vld_q  <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_type_q <= req_i.req_type;
      s1_ch_q   <= req_i.channel;
      s1_str_q  <= req_i.strength;
      s1_now_q  <= req_i.now_ms;
    end
  end

  // State memory: read in the cycle before the decision, written at the end.
  // A stalled request reads its entry again every cycle.
  assign raddr  = IDX_W'(stall ? s1_ch_q : req_i.channel);
  assign mem_we = s3_vld && s3.in_range;
  assign waddr  = IDX_W'(s3.channel);

  always_comb begin
    wdata.last_input  = s3.last_input;
    wdata.update_time = s3.update_time;
    wdata.level       = s3_level;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      state_mem[waddr] <= wdata;
    end
    rd_q    <= state_mem[raddr];
    w_ch_q  <= s3.channel;
    w_ent_q <= wdata;
  end

  // Current entry: memory data, then newer writes, youngest last.
  always_comb begin
    cur = rd_vld_q ? rd_q : '0;
    if (w_vld_q && (w_ch_q == s1_ch_q)) begin
      cur = w_ent_q;
    end
    if (s3_vld && s3.in_range && (s3.channel == s1_ch_q)) begin
      cur.last_input  = s3.last_input;
      cur.update_time = s3.update_time;
      cur.level       = s3.level;
    end
    if (s2_vld && s2.in_range && (s2.channel == s1_ch_q)) begin
      cur.last_input  = s2.last_input;
      cur.update_time = s2.update_time;
      cur.level       = s2.level;
    end
  end

  // Decide between taking a new strength, decaying and holding.
  always_comb begin
    in_range  = (32'(s1_ch_q) < CHANNELS);
    req_str   = (hsd_pkg::req_type_e'(s1_type_q) == hsd_pkg::REQ_TICK) ?
                cur.last_input : s1_str_q;
    changed   = (req_str != cur.last_input);
    since     = s1_now_q - ldt_q;
    period_ok = (since >= 32'(REFRESH_PERIOD_MS));
    hold_ok   = ((s1_now_q - cur.update_time) >= hold_delay_q);

    s1_stage.channel     = s1_ch_q;
    s1_stage.in_range    = in_range;
    s1_stage.take        = in_range && !changed && period_ok &&
                           (cur.level != 8'd0) && hold_ok;
    s1_stage.last_input  = req_str;
    s1_stage.update_time = changed ? s1_now_q : cur.update_time;
    if (!in_range) begin
      s1_stage.level = 8'd0;
    end else if (changed) begin
      s1_stage.level = req_str;
    end else begin
      s1_stage.level = cur.level;
    end
    s1_stage.since     = since[hsd_pkg::SINCE_W-1:0];
    s1_stage.since_sat = |since[31:hsd_pkg::SINCE_W];
  end

  // Interlock: wait while a decay on the same channel is still computing.
  assign stall = s1_vld_q &&
                 ((s2_vld && s2.take && (s2.channel == s1_ch_q)) ||
                  (s3_vld && s3.take && (s3.channel == s1_ch_q)));
  assign s1_adv = s1_vld_q && !stall;

  hsd_decay_pipe u_decay_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_vld_i      (s1_adv),
    .s1_i          (s1_stage),
    .decay_speed_i (decay_speed_q),
    .s2_vld_o      (s2_vld),
    .s2_o          (s2),
    .s3_vld_o      (s3_vld),
    .s3_o          (s3),
    .s3_level_o    (s3_level)
  );

  // Result queue.
  always_comb begin
    push_data.channel = s3.channel;
    push_data.level   = s3_level;
  end

  hsd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_vld),
    .push_data_i (push_data),
    .pop_i       (deliver),
    .vld_o       (fifo_vld),
    .data_o      (fifo_data)
  );

  assign rsp_o.valid       = fifo_vld;
  assign rsp_o.out_channel = fifo_data.channel;
  assign rsp_o.level       = fifo_data.level;
  assign rsp_o.duty        = {fifo_data.level, 4'd0};

`ifndef SYNTHESIS
  // Requests in flight never exceed the queue slots.
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hsd_pkg::OUT_CREDITS)
    else $error("request count exceeds result queue depth");

  // No queued result without a request in flight.
  a_empty_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !fifo_vld)
    else $error("result shown with no request in flight");

  // A decay step records the request time as the last decay time.
  a_decay_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_stage.take) |=> (ldt_q == $past(s1_now_q)))
    else $error("last decay time not updated by a decay step");
`endif

endmodule
